// File: hw/rtl/wscfb_pkg.sv
// ----------------------------------------------------------------------------
// wscfb_pkg
// Shared types and constants of the WebSocket client frame builder.
// ----------------------------------------------------------------------------
package wscfb_pkg;

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_CTRL = 2'd1,
    CMD_BYTE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CTRL_LONG  = 2'd1,
    ST_NO_FRAME   = 2'd2,
    ST_START_OPEN = 2'd3
  } status_t;

  localparam logic [3:0]  OPC_CONT     = 4'h0;
  localparam logic [3:0]  OPC_TEXT     = 4'h1;
  localparam logic [3:0]  OPC_BINARY   = 4'h2;
  localparam logic [6:0]  LEN_EXT16    = 7'd126;
  localparam logic [15:0] SHORT_LEN_LT = 16'd126;
  localparam logic [15:0] CTRL_MAX_LEN = 16'd125;

  localparam int JOB_BYTES   = 8;
  localparam int JOB_CNT_W   = $clog2(JOB_BYTES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [JOB_CNT_W-1:0] CNT_SHORT_HDR = JOB_CNT_W'(5);
  localparam logic [JOB_CNT_W-1:0] CNT_LONG_HDR  = JOB_CNT_W'(7);
  localparam logic [JOB_CNT_W-1:0] CNT_SINGLE    = JOB_CNT_W'(0);

  // One queued run of output bytes.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_CNT_W-1:0]      cnt_m1;
    logic                      last_fin;
    status_t                   status;
  } job_t;

endpackage

// File: hw/rtl/wscfb_front.sv
// ----------------------------------------------------------------------------
// wscfb_front
// Accepts requests, tracks frame state and turns each request into a byte run.
// ----------------------------------------------------------------------------
module wscfb_front
  import wscfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_frame_length,
  input  logic        in_binary,
  input  logic        in_final_req,
  input  logic [3:0]  in_control_opcode,
  input  logic [31:0] in_mask_key,
  input  logic [7:0]  in_payload_byte,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_job
);

  logic        continuing_r, continuing_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] mask_store_r, mask_store_nxt;
  logic [1:0]  mask_phase_r, mask_phase_nxt;

  logic        accept;
  logic [3:0]  opc;
  logic [7:0]  mask_byte;
  logic [15:0] left_dec;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign opc      = continuing_r ? OPC_CONT : (in_binary ? OPC_BINARY : OPC_TEXT);
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    case (mask_phase_r)
      2'd0:    mask_byte = mask_store_r[31:24];
      2'd1:    mask_byte = mask_store_r[23:16];
      2'd2:    mask_byte = mask_store_r[15:8];
      default: mask_byte = mask_store_r[7:0];
    endcase
  end

  always_comb begin
    continuing_nxt = continuing_r;
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    mask_store_nxt = mask_store_r;
    mask_phase_nxt = mask_phase_r;
    push_valid     = 1'b0;
    push_job       = '0;
    push_job.status = ST_OK;
    case (cmd_t'(in_command))
      CMD_DATA: begin
        push_valid = accept;
        if (frame_open_r) begin
          push_job.status = ST_START_OPEN;
        end else begin
          push_job.bytes[0] = {in_final_req, 3'b000, opc};
          if (in_frame_length < SHORT_LEN_LT) begin
            push_job.bytes[1] = {1'b1, in_frame_length[6:0]};
            push_job.bytes[2] = in_mask_key[31:24];
            push_job.bytes[3] = in_mask_key[23:16];
            push_job.bytes[4] = in_mask_key[15:8];
            push_job.bytes[5] = in_mask_key[7:0];
            push_job.cnt_m1   = CNT_SHORT_HDR;
          end else begin
            push_job.bytes[1] = {1'b1, LEN_EXT16};
            push_job.bytes[2] = in_frame_length[15:8];
            push_job.bytes[3] = in_frame_length[7:0];
            push_job.bytes[4] = in_mask_key[31:24];
            push_job.bytes[5] = in_mask_key[23:16];
            push_job.bytes[6] = in_mask_key[15:8];
            push_job.bytes[7] = in_mask_key[7:0];
            push_job.cnt_m1   = CNT_LONG_HDR;
          end
          push_job.last_fin = (in_frame_length == 16'd0);
          if (accept) begin
            continuing_nxt = !in_final_req;
            mask_store_nxt = in_mask_key;
            mask_phase_nxt = 2'd0;
            bytes_left_nxt = in_frame_length;
            frame_open_nxt = (in_frame_length != 16'd0);
          end
        end
      end
      CMD_CTRL: begin
        push_valid = accept;
        if (frame_open_r) begin
          push_job.status = ST_START_OPEN;
        end else if (in_frame_length > CTRL_MAX_LEN) begin
          push_job.status = ST_CTRL_LONG;
        end else begin
          push_job.bytes[0] = {1'b1, 3'b000, in_control_opcode};
          push_job.bytes[1] = {1'b1, in_frame_length[6:0]};
          push_job.bytes[2] = in_mask_key[31:24];
          push_job.bytes[3] = in_mask_key[23:16];
          push_job.bytes[4] = in_mask_key[15:8];
          push_job.bytes[5] = in_mask_key[7:0];
          push_job.cnt_m1   = CNT_SHORT_HDR;
          push_job.last_fin = (in_frame_length == 16'd0);
          if (accept) begin
            mask_store_nxt = in_mask_key;
            mask_phase_nxt = 2'd0;
            bytes_left_nxt = in_frame_length;
            frame_open_nxt = (in_frame_length != 16'd0);
          end
        end
      end
      CMD_BYTE: begin
        push_valid = accept;
        if (!frame_open_r) begin
          push_job.status = ST_NO_FRAME;
        end else begin
          push_job.bytes[0] = in_payload_byte ^ mask_byte;
          push_job.cnt_m1   = CNT_SINGLE;
          push_job.last_fin = (left_dec == 16'd0);
          if (accept) begin
            mask_phase_nxt = mask_phase_r + 2'd1;
            bytes_left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              frame_open_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      continuing_r <= 1'b0;
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
      mask_store_r <= '0;
      mask_phase_r <= '0;
    end else begin
      continuing_r <= continuing_nxt;
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      mask_store_r <= mask_store_nxt;
      mask_phase_r <= mask_phase_nxt;
    end
  end

endmodule

// File: hw/rtl/wscfb_queue.sv
// ----------------------------------------------------------------------------
// wscfb_queue
// Short FIFO of byte runs between the front and the back.
// ----------------------------------------------------------------------------
module wscfb_queue
  import wscfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/wscfb_back.sv
// ----------------------------------------------------------------------------
// wscfb_back
// Walks each queued run one byte per cycle into the output register, while the output is not stalled.
// ----------------------------------------------------------------------------
module wscfb_back
  import wscfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  output logic       job_pop,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_status
);

  logic [JOB_CNT_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic [1:0]           out_status_r;
  logic                 load, at_end;

  assign load    = job_valid && (!out_valid_r || out_ready);
  assign at_end  = (idx_r == job.cnt_m1);
  assign job_pop = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_end ? '0 : idx_r + JOB_CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= job.bytes[idx_r];
      out_last_r   <= at_end && job.last_fin;
      out_status_r <= job.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

// File: hw/rtl/websocket_client_frame_builder_core.sv
// ----------------------------------------------------------------------------
// websocket_client_frame_builder_core
// Masked client-side WebSocket frame builder producing a byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request per handshake. A start data
// or start control request yields a header run of six bytes (eight when the
// length needs the 16-bit extension): header, length, optional extended
// length, then the four mask-key bytes. A payload request yields one masked
// byte. A rejected request yields one byte 0 with an error code on out_status.
// Output channel (out_valid/out_ready): one byte per handshake, out_last on
// the byte that closes a frame.
// The first byte of a request passes through the run queue and then the output register.
// Throughput: the output register drains one byte per cycle while out_ready is
// high; payload requests sustain one per cycle while the queue has room, and a
// four-entry run queue keeps accepting requests behind a header run.
// Reset clears the frame state, the queue and the output valid flag.
// A stalled receiver holds the output byte; requests are accepted until the
// run queue is full, then in_ready drops.
// ----------------------------------------------------------------------------
module websocket_client_frame_builder_core
  import wscfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_frame_length,
  input  logic        in_binary,
  input  logic        in_final_req,
  input  logic [3:0]  in_control_opcode,
  input  logic [31:0] in_mask_key,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status
);

  logic push_valid, push_ready, pop_valid, pop;
  job_t push_job, pop_job;

  wscfb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_frame_length  (in_frame_length),
    .in_binary        (in_binary),
    .in_final_req     (in_final_req),
    .in_control_opcode(in_control_opcode),
    .in_mask_key      (in_mask_key),
    .in_payload_byte  (in_payload_byte),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_job         (push_job)
  );

  wscfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job)
  );

  wscfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_pop   (pop),
    .job       (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_status(out_status)
  );

endmodule

// File: hw/rtl/wscfb_checker.sv
// ----------------------------------------------------------------------------
// wscfb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module wscfb_checker
  import wscfb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last)
      && $stable(out_status))
    else $error("output changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_last && (out_byte == 8'd0))
    else $error("error byte malformed");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind websocket_client_frame_builder_core wscfb_checker u_wscfb_checker (.*);
